>>> hw/rtl/qubit_tensor_slice_contract_engine_defines.svh
// Assertion macros for the tensor slice and contract engine.
// Depends on aclk and aresetn being visible at the point of use.
`ifndef QUBIT_TENSOR_SLICE_CONTRACT_ENGINE_DEFINES_SVH
`define QUBIT_TENSOR_SLICE_CONTRACT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define QTSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define QTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);
`else
`define QTSC_ASSERT(lbl, prop, msg)
`define QTSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/qtsc_pkg.sv
// Shared types, constants and arithmetic helpers of the tensor engine.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps
package qtsc_pkg;

    localparam int RANK_CAP = 10;
    localparam int PART_W   = 32;
    localparam int FRAC_W   = PART_W - 5;
    localparam int ADDR_W   = RANK_CAP;
    localparam int DEPTH    = 1 << RANK_CAP;
    localparam int RANK_W   = 4;
    localparam int ENT_W    = 2 * PART_W;
    localparam int ACC_W    = PART_W + 8;
    localparam int STEP_W   = 3;

    typedef enum logic [2:0] {
        ACT_LOAD_A   = 3'd0,
        ACT_LOAD_B   = 3'd1,
        ACT_SET_MAP  = 3'd2,
        ACT_EXPAND   = 3'd3,
        ACT_SLICE    = 3'd4,
        ACT_CONTRACT = 3'd5,
        ACT_MULTIPLY = 3'd6,
        ACT_READ     = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANK  = 2'd1,
        ST_AXIS  = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    // sub-steps of one entry during a walk
    localparam logic [STEP_W-1:0] STEP_ISSUE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FETCH   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_PROD_RR = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PROD_II = 3'd3;
    localparam logic [STEP_W-1:0] STEP_PROD_RI = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PROD_IR = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ACC_IM  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_WR  = 3'd7;

    typedef struct packed {
        logic              latch;
        logic              eval;
        logic              walk;
        logic              wr;
        logic              commit;
        logic [STEP_W-1:0] step;
        logic [ADDR_W-1:0] cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t              act;
        status_t           err;
        logic [ADDR_W-1:0] last;
    } dp_sts_t;

    function automatic logic signed [PART_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-PART_W+1){1'b0}}, {(PART_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(PART_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(PART_W-1){1'b0}}};
        end
        return v[PART_W-1:0];
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [2*PART_W-1:0] p);
        logic signed [2*PART_W-1:0] t;
        logic signed [2*PART_W-1:0] s;
        t = p + ((2*PART_W)'(1) << (FRAC_W - 1));
        s = t >>> FRAC_W;
        return s[ACC_W-1:0];
    endfunction

endpackage

>>> hw/rtl/qtsc_ctrl.sv
// Controller of the tensor engine: action sequencing and entry walk counters.
// Depends on qtsc_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
module qtsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 out_load,
    input  qtsc_pkg::dp_sts_t    sts,
    output qtsc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_WALK = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [qtsc_pkg::ADDR_W-1:0]         cnt_reg, cnt_next;
    logic [qtsc_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [qtsc_pkg::STEP_W-1:0]         wr_step;
    logic                                is_walk;

    assign wr_step = (sts.act == qtsc_pkg::ACT_MULTIPLY) ? qtsc_pkg::STEP_MUL_WR
                                                         : qtsc_pkg::STEP_FETCH;
    assign is_walk = (sts.act == qtsc_pkg::ACT_EXPAND) || (sts.act == qtsc_pkg::ACT_SLICE) ||
                     (sts.act == qtsc_pkg::ACT_CONTRACT) || (sts.act == qtsc_pkg::ACT_MULTIPLY);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        cmd.step   = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.err == qtsc_pkg::ST_OK && is_walk) begin
                    cnt_next   = '0;
                    step_next  = qtsc_pkg::STEP_ISSUE;
                    state_next = S_WALK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                cmd.wr   = (step_reg == wr_step);
                if (step_reg == wr_step) begin
                    step_next = qtsc_pkg::STEP_ISSUE;
                    if (cnt_reg == sts.last) begin
                        state_next = S_FIN;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FIN: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the beat
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            step_reg  <= qtsc_pkg::STEP_ISSUE;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> hw/rtl/qtsc_datapath.sv
// Datapath of the tensor engine: tensor memories, ranks, axis map, checks,
// address generation, saturating add and shared rounding multiplier.
// Depends on qtsc_pkg; controlled by qtsc_ctrl.
`timescale 1ns / 1ps
module qtsc_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  qtsc_pkg::ctrl_cmd_t                cmd,
    output qtsc_pkg::dp_sts_t                  sts,
    input  logic [2:0]                         action,
    input  logic [qtsc_pkg::ADDR_W-1:0]        index,
    input  logic [qtsc_pkg::RANK_W-1:0]        rank_value,
    input  logic [qtsc_pkg::RANK_W-1:0]        axis,
    input  logic [qtsc_pkg::RANK_W-1:0]        map_slot,
    input  logic                               fill_bit,
    input  logic signed [qtsc_pkg::PART_W-1:0] re_in,
    input  logic signed [qtsc_pkg::PART_W-1:0] im_in,
    input  logic                               cfg_we,
    input  logic [qtsc_pkg::RANK_W-1:0]        cfg_data,
    output logic [1:0]                         status,
    output logic [qtsc_pkg::RANK_W-1:0]        rank_out,
    output logic signed [qtsc_pkg::PART_W-1:0] re_out,
    output logic signed [qtsc_pkg::PART_W-1:0] im_out
);

    localparam int PW = qtsc_pkg::PART_W;
    localparam int AW = qtsc_pkg::ADDR_W;
    localparam int RW = qtsc_pkg::RANK_W;
    localparam int EW = qtsc_pkg::ENT_W;
    localparam int CW = qtsc_pkg::ACC_W;
    localparam int MR = qtsc_pkg::RANK_CAP;

    // latched item
    qtsc_pkg::act_t        act_reg;
    logic [AW-1:0]         index_reg;
    logic [RW-1:0]         rv_reg, axis_reg, slot_reg;
    logic                  fill_reg;
    logic signed [PW-1:0]  re_reg, im_reg;

    // architectural state
    logic [RW-1:0]         rank_a_reg, rank_b_reg, limit_reg;
    logic [RW-1:0]         map_reg [MR];
    qtsc_pkg::status_t     err_reg, err_next;
    logic [AW-1:0]         last_reg, last_next;

    // memories
    logic [EW-1:0]         mem_a [qtsc_pkg::DEPTH];
    logic [EW-1:0]         mem_b [qtsc_pkg::DEPTH];
    logic [EW-1:0]         rd_a0_reg, rd_a1_reg, rd_b_reg;

    // multiply operands and accumulators
    logic signed [PW-1:0]   xr_reg, xi_reg, yr_reg, yi_reg;
    logic signed [2*PW-1:0] prod_reg, prod_next;
    logic signed [CW-1:0]   acc_re_reg, acc_im_reg;
    logic signed [PW-1:0]   mop_a, mop_b;

    logic [RW:0]           sum_rank;
    logic [RW-1:0]         lim, sub;
    logic [AW:0]           span, span_m1, one_rv, one_ra;
    logic [AW-1:0]         n, lowm, bitsub, src, ra0, ra1, bi, wa;
    logic [EW-1:0]         wd, walk_wd;
    logic                  we_a, we_b, ok;
    logic signed [PW-1:0]  a0_re, a0_im, a1_re, a1_im;
    logic signed [CW-1:0]  sum_re, sum_im;

    assign sum_rank = {1'b0, rank_a_reg} + {1'b0, rv_reg};
    assign lim      = (limit_reg < RW'(MR)) ? limit_reg : RW'(MR);
    assign one_rv   = (AW+1)'(1) << rv_reg;
    assign one_ra   = (AW+1)'(1) << rank_a_reg;
    assign ok       = (err_reg == qtsc_pkg::ST_OK);

    always_comb begin
        err_next = qtsc_pkg::ST_OK;
        unique case (act_reg) inside
            qtsc_pkg::ACT_LOAD_A, qtsc_pkg::ACT_LOAD_B: begin
                if (rv_reg > RW'(MR)) begin
                    err_next = qtsc_pkg::ST_RANK;
                end else if ({1'b0, index_reg} >= one_rv) begin
                    err_next = qtsc_pkg::ST_INDEX;
                end
            end
            qtsc_pkg::ACT_SET_MAP: begin
                if (slot_reg >= RW'(MR)) err_next = qtsc_pkg::ST_INDEX;
            end
            qtsc_pkg::ACT_EXPAND: begin
                if (sum_rank > {1'b0, lim}) err_next = qtsc_pkg::ST_RANK;
            end
            qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT: begin
                if (axis_reg == '0 || axis_reg > rank_a_reg) err_next = qtsc_pkg::ST_AXIS;
            end
            qtsc_pkg::ACT_MULTIPLY: begin
                for (int s = 0; s < MR; s++) begin
                    if (RW'(s) < rank_b_reg && map_reg[s] >= rank_a_reg) begin
                        err_next = qtsc_pkg::ST_AXIS;
                    end
                end
            end
            qtsc_pkg::ACT_READ: begin
                if ({1'b0, index_reg} >= one_ra) err_next = qtsc_pkg::ST_INDEX;
            end
        endcase
    end

    // number of entries walked, minus one
    always_comb begin
        unique case (act_reg) inside
            qtsc_pkg::ACT_EXPAND:                         span = (AW+1)'(1) << sum_rank;
            qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT:  span = (AW+1)'(1) << (rank_a_reg - 1'b1);
            qtsc_pkg::ACT_MULTIPLY:                       span = one_ra;
            default:                                      span = (AW+1)'(1);
        endcase
        span_m1   = span - 1'b1;
        last_next = span_m1[AW-1:0];
    end

    // expand walks downward so sources are read before they are overwritten
    assign n      = (act_reg == qtsc_pkg::ACT_EXPAND) ? (last_reg - cmd.cnt) : cmd.cnt;
    assign sub    = rank_a_reg - axis_reg;
    assign bitsub = AW'(1) << sub;
    assign lowm   = bitsub - 1'b1;
    assign src    = ((n & ~lowm) << 1) | (n & lowm);
    assign ra1    = src | bitsub;

    always_comb begin
        unique case (act_reg) inside
            qtsc_pkg::ACT_EXPAND:   ra0 = n >> rv_reg;
            qtsc_pkg::ACT_SLICE:    ra0 = fill_reg ? (src | bitsub) : src;
            qtsc_pkg::ACT_CONTRACT: ra0 = src;
            qtsc_pkg::ACT_MULTIPLY: ra0 = n;
            default:                ra0 = index_reg;
        endcase
    end

    // gather B's index through the axis map
    always_comb begin
        logic [RW-1:0] sh;
        logic [RW-1:0] pos;
        logic [AW-1:0] shifted;
        bi = '0;
        for (int s = 0; s < MR; s++) begin
            sh      = rank_a_reg - map_reg[s] - 1'b1;
            pos     = rank_b_reg - RW'(s) - 1'b1;
            shifted = n >> sh;
            if (RW'(s) < rank_b_reg) begin
                bi = bi | (AW'(shifted[0]) << pos);
            end
        end
    end

    assign a0_re  = rd_a0_reg[PW-1:0];
    assign a0_im  = rd_a0_reg[EW-1:PW];
    assign a1_re  = rd_a1_reg[PW-1:0];
    assign a1_im  = rd_a1_reg[EW-1:PW];
    assign sum_re = CW'(a0_re) + CW'(a1_re);
    assign sum_im = CW'(a0_im) + CW'(a1_im);

    always_comb begin
        unique case (act_reg) inside
            qtsc_pkg::ACT_CONTRACT: walk_wd = {qtsc_pkg::sat(sum_im), qtsc_pkg::sat(sum_re)};
            qtsc_pkg::ACT_MULTIPLY: walk_wd = {qtsc_pkg::sat(acc_im_reg),
                                               qtsc_pkg::sat(acc_re_reg)};
            default:                walk_wd = rd_a0_reg;
        endcase
    end

    assign we_a = (cmd.walk && cmd.wr) ||
                  (cmd.commit && ok && act_reg == qtsc_pkg::ACT_LOAD_A);
    assign we_b = cmd.commit && ok && act_reg == qtsc_pkg::ACT_LOAD_B;
    assign wa   = cmd.walk ? n : index_reg;
    assign wd   = cmd.walk ? walk_wd : {im_reg, re_reg};

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wa] <= wd;
        end
        rd_a0_reg <= mem_a[ra0];
        rd_a1_reg <= mem_a[ra1];
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[index_reg] <= {im_reg, re_reg};
        end
        rd_b_reg <= mem_b[bi];
    end

    // one shared multiplier, four part products per entry
    always_comb begin
        case (cmd.step)
            qtsc_pkg::STEP_PROD_II: begin mop_a = xi_reg; mop_b = yi_reg; end
            qtsc_pkg::STEP_PROD_RI: begin mop_a = xr_reg; mop_b = yi_reg; end
            qtsc_pkg::STEP_PROD_IR: begin mop_a = xi_reg; mop_b = yr_reg; end
            default:                begin mop_a = xr_reg; mop_b = yr_reg; end
        endcase
        prod_next = mop_a * mop_b;
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk) begin
            case (cmd.step)
                qtsc_pkg::STEP_FETCH: begin
                    xr_reg <= a0_re;
                    xi_reg <= a0_im;
                    yr_reg <= rd_b_reg[PW-1:0];
                    yi_reg <= rd_b_reg[EW-1:PW];
                end
                qtsc_pkg::STEP_PROD_RR: prod_reg <= prod_next;
                qtsc_pkg::STEP_PROD_II: begin
                    acc_re_reg <= qtsc_pkg::rnd(prod_reg);
                    prod_reg   <= prod_next;
                end
                qtsc_pkg::STEP_PROD_RI: begin
                    acc_re_reg <= acc_re_reg - qtsc_pkg::rnd(prod_reg);
                    prod_reg   <= prod_next;
                end
                qtsc_pkg::STEP_PROD_IR: begin
                    acc_im_reg <= qtsc_pkg::rnd(prod_reg);
                    prod_reg   <= prod_next;
                end
                qtsc_pkg::STEP_ACC_IM: acc_im_reg <= acc_im_reg + qtsc_pkg::rnd(prod_reg);
                default: ;
            endcase
        end
    end

    // item fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg   <= qtsc_pkg::act_t'(action);
            index_reg <= index;
            rv_reg    <= rank_value;
            axis_reg  <= axis;
            slot_reg  <= map_slot;
            fill_reg  <= fill_bit;
            re_reg    <= re_in;
            im_reg    <= im_in;
        end
        if (cmd.eval) begin
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_a_reg <= '0;
            rank_b_reg <= '0;
            limit_reg  <= RW'(10);
            err_reg    <= qtsc_pkg::ST_OK;
            for (int i = 0; i < MR; i++) begin
                map_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
            if (cmd.eval) begin
                err_reg <= err_next;
            end
            if (cmd.commit && ok) begin
                unique case (act_reg) inside
                    qtsc_pkg::ACT_LOAD_A:   rank_a_reg <= rv_reg;
                    qtsc_pkg::ACT_LOAD_B:   rank_b_reg <= rv_reg;
                    qtsc_pkg::ACT_SET_MAP:  map_reg[slot_reg] <= axis_reg;
                    qtsc_pkg::ACT_EXPAND:   rank_a_reg <= sum_rank[RW-1:0];
                    qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT:
                                            rank_a_reg <= rank_a_reg - 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign sts.act  = act_reg;
    assign sts.err  = err_next;
    assign sts.last = last_reg;

    assign status   = err_reg;
    assign rank_out = rank_a_reg;
    assign re_out   = (act_reg == qtsc_pkg::ACT_READ && ok) ? a0_re : '0;
    assign im_out   = (act_reg == qtsc_pkg::ACT_READ && ok) ? a0_im : '0;

endmodule

>>> hw/rtl/qubit_tensor_slice_contract_engine.sv
// Top level of the complex tensor slice and contract engine.
// Depends on qtsc_pkg, qtsc_ctrl, qtsc_datapath and the defines header.
//
//   channel   dir  group                       content
//   s_        in   s_tvalid/s_tready/s_tdata   one action with its operands
//   m_        out  m_tvalid/m_tready/m_tdata   status, rank and read entry
//   cfg_      in   cfg_valid/cfg_ready         rank_limit register
//
// Load, set map and read pass from accept through evaluation and commit to the result.
// Expand, slice and contract walk the entries with an issue and a fetch step each (memory
// read latency); multiply walks each entry through the sub-steps from issue to write
// through the one shared multiplier, for up to 1024 entries.
// Reset is synchronous and active low; the tensor memories are not cleared.
// The next action is accepted while a result still waits on a stalled m_ side.
`timescale 1ns / 1ps
`include "qubit_tensor_slice_contract_engine_defines.svh"
module qubit_tensor_slice_contract_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // index, rank_value, axis, map_slot, fill_bit, re_in, im_in
    input  logic [2:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // status, rank_out, re_out, im_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    qtsc_pkg::ctrl_cmd_t                cmd;
    qtsc_pkg::dp_sts_t                  sts;
    logic                               out_load, out_free;
    logic [1:0]                         status;
    logic [qtsc_pkg::RANK_W-1:0]        rank_out;
    logic signed [qtsc_pkg::PART_W-1:0] re_out, im_out;
    logic                               m_tvalid_reg;
    logic [71:0]                        m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    qtsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .sts      (sts),
        .cmd      (cmd)
    );

    qtsc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .action     (s_tuser),
        .index      (s_tdata[9:0]),
        .rank_value (s_tdata[13:10]),
        .axis       (s_tdata[17:14]),
        .map_slot   (s_tdata[21:18]),
        .fill_bit   (s_tdata[22]),
        .re_in      (s_tdata[54:23]),
        .im_in      (s_tdata[86:55]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .status     (status),
        .rank_out   (rank_out),
        .re_out     (re_out),
        .im_out     (im_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, im_out, re_out, rank_out, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `QTSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `QTSC_ASSERT(a_rank_bound, m_tvalid |-> m_tdata[5:2] <= 4'(qtsc_pkg::RANK_CAP), "rank too large")
    `QTSC_ASSERT(a_err_no_data, m_tvalid && m_tdata[1:0] != qtsc_pkg::ST_OK |-> m_tdata[69:6] == '0, "data on error")

endmodule

>>> tb/tb_qubit_tensor_slice_contract_engine.sv
// Self-checking testbench for the complex tensor slice and contract engine.
// Drives actions on the s_ stream, checks every m_ beat against a predictor
// held in a scoreboard class; depends on qtsc_pkg and the engine RTL only.
`timescale 1ns / 1ps
module tb_qubit_tensor_slice_contract_engine;

    localparam int  NUM_ENTRIES = 1024;
    localparam int  ITEM_TARGET = 580;
    localparam int  RANK_CAP    = qtsc_pkg::RANK_CAP;
    localparam int  FRAC_W      = qtsc_pkg::FRAC_W;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        qtsc_pkg::act_t     act;
        logic [9:0]         index;
        logic [3:0]         rank_value;
        logic [3:0]         axis;
        logic [3:0]         map_slot;
        logic               fill;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } tensor_op_t;

    typedef struct packed {
        qtsc_pkg::status_t  status;
        logic [3:0]         rank;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } tensor_res_t;

    class tensor_scoreboard;
        int          a_re[NUM_ENTRIES];
        int          a_im[NUM_ENTRIES];
        int          b_re[NUM_ENTRIES];
        int          b_im[NUM_ENTRIES];
        bit          a_def[NUM_ENTRIES];
        bit          b_def[NUM_ENTRIES];
        logic [3:0]  amap[RANK_CAP];
        int          rank_a;
        int          rank_b;
        int          rank_limit;
        tensor_res_t expected_q[$];
        int          errors;

        function new();
            foreach (a_def[i]) begin
                a_def[i] = 0;
                b_def[i] = 0;
            end
            foreach (amap[i]) amap[i] = 0;
            rank_a = 0;
            rank_b = 0;
            rank_limit = 10;
            errors = 0;
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        // round to nearest, ties up, down to the fraction width
        function longint rmul(int x, int y);
            longint v;
            v = longint'(x) * longint'(y) + (64'sd1 <<< (FRAC_W - 1));
            return v >>> FRAC_W;
        endfunction

        function bit a_full();
            for (int n = 0; n < (1 << rank_a); n++) if (!a_def[n]) return 0;
            return 1;
        endfunction

        function bit b_full();
            for (int n = 0; n < (1 << rank_b); n++) if (!b_def[n]) return 0;
            return 1;
        endfunction

        function bit map_bad();
            for (int s = 0; s < rank_b && s < RANK_CAP; s++)
                if (amap[s] >= rank_a) return 1;
            return 0;
        endfunction

        function int bound();
            return rank_limit < RANK_CAP ? rank_limit : RANK_CAP;
        endfunction

        // true when the action never touches an entry that was never written
        function bit is_safe(tensor_op_t op);
            case (op.act) inside
                qtsc_pkg::ACT_READ:
                    return op.index >= (1 << rank_a) || a_def[op.index];
                qtsc_pkg::ACT_EXPAND:
                    return rank_a + op.rank_value > bound() || a_full();
                qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT:
                    return op.axis == 0 || op.axis > rank_a || a_full();
                qtsc_pkg::ACT_MULTIPLY:
                    return map_bad() || (a_full() && b_full());
                default:
                    return 1;
            endcase
        endfunction

        function void set_limit(int v);
            rank_limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(tensor_op_t op);
            tensor_res_t r;
            int sub, step, src, bi, xr, xi, yr, yi, rv;
            r.status = qtsc_pkg::ST_OK;
            r.re = 0;
            r.im = 0;
            rv = op.rank_value;
            case (op.act) inside
                qtsc_pkg::ACT_LOAD_A, qtsc_pkg::ACT_LOAD_B: begin
                    if (rv > RANK_CAP) r.status = qtsc_pkg::ST_RANK;
                    else if (op.index >= (1 << rv)) r.status = qtsc_pkg::ST_INDEX;
                    else if (op.act == qtsc_pkg::ACT_LOAD_A) begin
                        rank_a = rv;
                        a_re[op.index] = op.re;
                        a_im[op.index] = op.im;
                        a_def[op.index] = 1;
                    end else begin
                        rank_b = rv;
                        b_re[op.index] = op.re;
                        b_im[op.index] = op.im;
                        b_def[op.index] = 1;
                    end
                end
                qtsc_pkg::ACT_SET_MAP: begin
                    if (op.map_slot >= RANK_CAP) r.status = qtsc_pkg::ST_INDEX;
                    else amap[op.map_slot] = op.axis;
                end
                qtsc_pkg::ACT_EXPAND: begin
                    if (rank_a + rv > bound()) r.status = qtsc_pkg::ST_RANK;
                    else begin
                        rank_a += rv;
                        // walk downward so each source is read before it is overwritten
                        for (int n = (1 << rank_a) - 1; n >= 0; n--) begin
                            a_re[n] = a_re[n >> rv];
                            a_im[n] = a_im[n >> rv];
                            a_def[n] = a_def[n >> rv];
                        end
                    end
                end
                qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT: begin
                    if (op.axis == 0 || op.axis > rank_a) r.status = qtsc_pkg::ST_AXIS;
                    else begin
                        sub = rank_a - op.axis;
                        step = 1 << sub;
                        rank_a -= 1;
                        for (int n = 0; n < (1 << rank_a); n++) begin
                            src = ((n >> sub) << (sub + 1)) | (n & (step - 1));
                            if (op.act == qtsc_pkg::ACT_SLICE) begin
                                a_re[n] = a_re[src + op.fill * step];
                                a_im[n] = a_im[src + op.fill * step];
                                a_def[n] = a_def[src + op.fill * step];
                            end else begin
                                a_re[n] = sat(longint'(a_re[src]) + a_re[src + step]);
                                a_im[n] = sat(longint'(a_im[src]) + a_im[src + step]);
                                a_def[n] = a_def[src] & a_def[src + step];
                            end
                        end
                    end
                end
                qtsc_pkg::ACT_MULTIPLY: begin
                    if (map_bad()) r.status = qtsc_pkg::ST_AXIS;
                    else begin
                        for (int n = 0; n < (1 << rank_a); n++) begin
                            bi = 0;
                            for (int s = 0; s < rank_b && s < RANK_CAP; s++)
                                bi |= ((n >> (rank_a - amap[s] - 1)) & 1) << (rank_b - s - 1);
                            bi &= NUM_ENTRIES - 1;
                            xr = a_re[n];
                            xi = a_im[n];
                            yr = b_re[bi];
                            yi = b_im[bi];
                            a_re[n] = sat(rmul(xr, yr) - rmul(xi, yi));
                            a_im[n] = sat(rmul(xr, yi) + rmul(xi, yr));
                        end
                    end
                end
                default: begin
                    if (op.index >= (1 << rank_a)) r.status = qtsc_pkg::ST_INDEX;
                    else begin
                        r.re = a_re[op.index];
                        r.im = a_im[op.index];
                    end
                end
            endcase
            r.rank = rank_a[3:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(tensor_res_t got);
            tensor_res_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d rank %0d re %0d im %0d",
                         $time, got.status, got.rank, got.re, got.im);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.rank !== want.rank) begin
                $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
                errors++;
            end
            if (got.re !== want.re) begin
                $display("%0t: re expected %0d actual %0d", $time, want.re, got.re);
                errors++;
            end
            if (got.im !== want.im) begin
                $display("%0t: im expected %0d actual %0d", $time, want.im, got.im);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    tensor_scoreboard sb = new();
    int     items_sent;
    int     tx_burst;
    int     rx_burst;
    int     rx_hold;
    longint cycles;

    qubit_tensor_slice_contract_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check each beat, then hold tready low for a drawn stall outside bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(tensor_res_t'{qtsc_pkg::status_t'(m_tdata[1:0]), m_tdata[5:2],
                                              m_tdata[37:6], m_tdata[69:38]});
                if (rx_burst > 0) begin
                    rx_burst--;
                    rx_hold = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_burst = $urandom_range(5, 25);
                    rx_hold = 0;
                end else begin
                    rx_hold = $urandom_range(0, 16);
                end
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_tready <= (rx_hold == 0);
        end
    end

    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0800_0000;  // +1.0
            4: return 32'hF800_0000;  // -1.0
            default: return $urandom();
        endcase
    endfunction

    function automatic tensor_op_t noise_op(qtsc_pkg::act_t act);
        tensor_op_t op;
        op.act = act;
        op.index = 10'($urandom_range(0, 1023));
        op.rank_value = 4'($urandom_range(0, 15));
        op.axis = 4'($urandom_range(0, 15));
        op.map_slot = 4'($urandom_range(0, 15));
        op.fill = 1'($urandom_range(0, 1));
        op.re = pick_part();
        op.im = pick_part();
        return op;
    endfunction

    function automatic tensor_op_t make_op(qtsc_pkg::act_t act, int index, int rv, int axis,
                                           int slot, int fill, logic [31:0] re,
                                           logic [31:0] im);
        tensor_op_t op;
        op = noise_op(act);
        op.index = 10'(index);
        op.rank_value = 4'(rv);
        op.axis = 4'(axis);
        op.map_slot = 4'(slot);
        op.fill = 1'(fill);
        op.re = re;
        op.im = im;
        return op;
    endfunction

    task automatic send_op(tensor_op_t op);
        int gap;
        if (tx_burst > 0) begin
            tx_burst--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            tx_burst = $urandom_range(5, 25);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op.act;
        s_tdata <= {1'b0, op.im, op.re, op.fill, op.map_slot, op.axis, op.rank_value, op.index};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    task automatic write_rank_limit(int v);
        drain();
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= 4'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
    endtask

    task automatic fill_tensor(qtsc_pkg::act_t act, int r);
        for (int i = 0; i < (1 << r); i++)
            send_op(make_op(act, i, r, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 1), pick_part(), pick_part()));
    endtask

    // point every live map slot at a valid axis of A, then multiply
    task automatic mapped_multiply();
        for (int s = 0; s < sb.rank_b; s++)
            if (sb.rank_a > 0)
                send_op(make_op(qtsc_pkg::ACT_SET_MAP, $urandom_range(0, 1023),
                                $urandom_range(0, 15), $urandom_range(0, sb.rank_a - 1), s,
                                $urandom_range(0, 1), $urandom(), $urandom()));
        send_op(noise_op(qtsc_pkg::ACT_MULTIPLY));
    endtask

    function automatic int pick_rank();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
    endfunction

    task automatic random_op();
        tensor_op_t op;
        bit shaped;
        op = noise_op(qtsc_pkg::act_t'($urandom_range(0, 7)));
        shaped = ($urandom_range(0, 9) < 8);
        case (op.act) inside
            qtsc_pkg::ACT_LOAD_A: if (shaped) begin
                op.rank_value = 4'(sb.rank_a);
                op.index = 10'($urandom_range(0, (1 << sb.rank_a) - 1));
            end
            qtsc_pkg::ACT_LOAD_B: if (shaped) begin
                op.rank_value = 4'(sb.rank_b);
                op.index = 10'($urandom_range(0, (1 << sb.rank_b) - 1));
            end
            qtsc_pkg::ACT_SET_MAP: if (shaped && sb.rank_b > 0 && sb.rank_a > 0) begin
                op.map_slot = 4'($urandom_range(0, sb.rank_b - 1));
                op.axis = 4'($urandom_range(0, sb.rank_a - 1));
            end
            qtsc_pkg::ACT_EXPAND: if (shaped) op.rank_value = 4'($urandom_range(0, 2));
            qtsc_pkg::ACT_SLICE, qtsc_pkg::ACT_CONTRACT: if (shaped && sb.rank_a > 0)
                op.axis = 4'($urandom_range(1, sb.rank_a));
            qtsc_pkg::ACT_READ: if (shaped)
                op.index = 10'($urandom_range(0, (1 << sb.rank_a) - 1));
            default: ;
        endcase
        // drop anything that would read an entry never written
        if (sb.is_safe(op)) send_op(op);
    endtask

    task automatic random_phase(int target);
        int pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 12 || (!sb.a_full() && pick < 40))
                fill_tensor(qtsc_pkg::ACT_LOAD_A, pick_rank());
            else if (pick < 20 || (!sb.b_full() && pick < 50))
                fill_tensor(qtsc_pkg::ACT_LOAD_B, pick_rank());
            else if (pick < 30) mapped_multiply();
            else if (pick < 33 && sb.a_full() && sb.rank_a < 3 && sb.bound() >= 10)
                send_op(make_op(qtsc_pkg::ACT_EXPAND, 0, 10 - sb.rank_a, 0, 0, 0, 0, 0));
            else random_op();
        end
    endtask

    task automatic directed_ops();
        send_op(make_op(qtsc_pkg::ACT_READ, 1, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_SLICE, 0, 0, 1, 0, 1, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_CONTRACT, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_LOAD_A, 0, 11, 0, 0, 0, 1, 1));
        send_op(make_op(qtsc_pkg::ACT_LOAD_B, 0, 15, 0, 0, 0, 1, 1));
        send_op(make_op(qtsc_pkg::ACT_LOAD_A, 2, 1, 0, 0, 0, 1, 1));
        send_op(make_op(qtsc_pkg::ACT_LOAD_A, 0, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_op(make_op(qtsc_pkg::ACT_LOAD_A, 1, 1, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_op(make_op(qtsc_pkg::ACT_LOAD_B, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_op(make_op(qtsc_pkg::ACT_SET_MAP, 0, 0, 15, 10, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_SET_MAP, 0, 0, 15, 15, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_MULTIPLY, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_READ, 1023, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_EXPAND, 0, 15, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_EXPAND, 0, 1, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_CONTRACT, 0, 0, 2, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_SLICE, 0, 0, 2, 0, 1, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_LOAD_B, 0, 1, 0, 0, 0, 32'h0800_0000, 32'hF800_0000));
        send_op(make_op(qtsc_pkg::ACT_LOAD_B, 1, 1, 0, 0, 0, 32'h0400_0001, 32'hFBFF_FFFF));
        send_op(make_op(qtsc_pkg::ACT_SET_MAP, 0, 0, 5, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_MULTIPLY, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_SET_MAP, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_MULTIPLY, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(qtsc_pkg::ACT_LOAD_A, 1023, 10, 0, 0, 0, 32'h1234_5678,
                        32'h8765_4321));
        send_op(make_op(qtsc_pkg::ACT_READ, 1023, 0, 0, 0, 0, 0, 0));
    endtask

    initial begin
        int limits[4];
        int per_phase;
        limits = '{0, 15, 4, 10};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= qtsc_pkg::ACT_LOAD_A;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        cycles <= 0;
        items_sent = 0;
        tx_burst = 0;
        rx_burst = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_ops();
        per_phase = (ITEM_TARGET - items_sent) / 5;
        random_phase(items_sent + per_phase / 2);
        // hold off until the engine has answered everything, then resume mid-phase
        drain();
        random_phase(items_sent + per_phase / 2);
        foreach (limits[i]) begin
            write_rank_limit(limits[i]);
            random_phase(items_sent + per_phase);
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> qubit_tensor_slice_contract_engine.f
+incdir+hw/rtl
hw/rtl/qtsc_pkg.sv
hw/rtl/qtsc_ctrl.sv
hw/rtl/qtsc_datapath.sv
hw/rtl/qubit_tensor_slice_contract_engine.sv
tb/tb_qubit_tensor_slice_contract_engine.sv
